// ===== design/lmq_pkg.sv =====
// shared widths, operation codes, controller states and control/status bundles
package lmq_pkg;

  localparam int CMD_W  = 2;
  localparam int QID_W  = 7;
  localparam int ELEM_W = 10;

  typedef enum logic [CMD_W-1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_MERGE  = 2'd2
  } lmq_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LINK,
    ST_MOVE,
    ST_OUT
  } lmq_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic link_wr;
    logic move_wr;
    logic clr_wr;
    logic out_load;
  } lmq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic pop_more;
    logic merge_go;
    logic out_free;
  } lmq_sts_t;

endpackage

// ===== design/lmq_in_if.sv =====
// command channel: valid/ready with one command word
interface lmq_in_if import lmq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [QID_W-1:0]  queue_id;
  logic [ELEM_W-1:0] element;
  logic [QID_W-1:0]  dest_queue;

  modport source (output valid, cmd, queue_id, element, dest_queue, input ready);
  modport sink   (input valid, cmd, queue_id, element, dest_queue, output ready);
endinterface

// ===== design/lmq_out_if.sv =====
// result channel: valid/ready with one result word
interface lmq_out_if import lmq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [ELEM_W-1:0] popped_element;

  modport source (output valid, status, popped_element, input ready);
  modport sink   (input valid, status, popped_element, output ready);
endinterface

// ===== design/lmq_ctrl.sv =====
// controller state machine: sequences reads, writes and result hand-off
module lmq_ctrl import lmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lmq_sts_t sts,
  output lmq_ctl_t ctl
);

  lmq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.pop_more) begin
          state_nxt = ST_LINK;
        end else if (sts.merge_go) begin
          state_nxt = ST_MOVE;
        end else if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_LINK, ST_MOVE: begin
        ctl.link_wr = (state_r == ST_LINK);
        ctl.move_wr = (state_r == ST_MOVE);
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // result still blocked by an untaken word
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/lmq_dp.sv =====
// datapath: pointer and link memories, command registers, result register
module lmq_dp import lmq_pkg::*; #(
  parameter int NUM_QUEUES   = 128,
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [QID_W-1:0]  in_queue_id,
  input  logic [ELEM_W-1:0] in_element,
  input  logic [QID_W-1:0]  in_dest_queue,
  input  lmq_ctl_t          ctl,
  output lmq_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic [ELEM_W-1:0] out_popped_element
);

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int EW = $clog2(NUM_ELEMENTS);

  function automatic logic [QW-1:0] qidx(input logic [QID_W-1:0] q);
    logic [QW+QID_W-1:0] w;
    w = {{QW{1'b0}}, q};
    return w[QW-1:0];
  endfunction

  function automatic logic [EW-1:0] eidx(input logic [ELEM_W-1:0] e);
    logic [EW+ELEM_W-1:0] w;
    w = {{EW{1'b0}}, e};
    return w[EW-1:0];
  endfunction

  logic [ELEM_W-1:0] head_mem [NUM_QUEUES];
  logic [ELEM_W-1:0] tail_mem [NUM_QUEUES];
  logic              ne_mem   [NUM_QUEUES];
  logic [ELEM_W-1:0] link_mem [NUM_ELEMENTS];

  // captured command
  logic [CMD_W-1:0]  cmd_r;
  logic [QW-1:0]     q_r;
  logic [QW-1:0]     dst_r;
  logic [ELEM_W-1:0] elem_r;
  logic              q_ok_r, dst_ok_r, elem_ok_r, dst_diff_r;

  // registered read data
  logic [ELEM_W-1:0] head_rd_r, tail_q_rd_r, tail_d_rd_r, link_rd_r;
  logic              ne_q_rd_r, ne_d_rd_r;

  logic [QW-1:0]     clr_cnt_r;
  logic              out_valid_r;
  logic              out_status_r;
  logic [ELEM_W-1:0] out_popped_r;

  logic              is_app, pop_hit, pop_more, merge_go;
  logic              res_status;
  logic [ELEM_W-1:0] res_popped;

  logic              hd_we, tl_we, ne_we, lk_we, lk_re;
  logic [QW-1:0]     hd_wa, tl_wa, ne_wa;
  logic [EW-1:0]     lk_wa;
  logic [ELEM_W-1:0] hd_wd, tl_wd, lk_wd;
  logic              ne_wd;

  // decode of the captured command against the read data
  always_comb begin
    is_app   = (cmd_r == OP_APPEND) && q_ok_r && elem_ok_r;
    pop_hit  = (cmd_r == OP_POP) && q_ok_r && ne_q_rd_r;
    pop_more = pop_hit && (head_rd_r != tail_q_rd_r);
    merge_go = (cmd_r == OP_MERGE) && q_ok_r && dst_ok_r && dst_diff_r && ne_q_rd_r;
    res_status = (cmd_r == OP_POP) && q_ok_r && !ne_q_rd_r;
    res_popped = pop_hit ? head_rd_r : '0;
  end

  always_comb begin
    hd_we = ctl.link_wr ||
            (ctl.exec && ((is_app && !ne_q_rd_r) || (merge_go && !ne_d_rd_r)));
    hd_wa = (ctl.exec && merge_go) ? dst_r : q_r;
    if (ctl.link_wr) begin
      hd_wd = link_rd_r;
    end else if (merge_go) begin
      hd_wd = head_rd_r;
    end else begin
      hd_wd = elem_r;
    end

    tl_we = ctl.exec && (is_app || merge_go);
    tl_wa = merge_go ? dst_r : q_r;
    tl_wd = merge_go ? tail_q_rd_r : elem_r;

    // link the old tail forward when the target queue already holds words
    lk_we = ctl.exec && ((is_app && ne_q_rd_r) || (merge_go && ne_d_rd_r));
    lk_wa = merge_go ? eidx(tail_d_rd_r) : eidx(tail_q_rd_r);
    lk_wd = merge_go ? head_rd_r : elem_r;
    lk_re = ctl.exec && pop_more;
  end

  always_comb begin
    ne_we = 1'b0;
    ne_wa = q_r;
    ne_wd = 1'b0;
    if (ctl.clr_wr) begin
      ne_we = 1'b1;
      ne_wa = clr_cnt_r;
    end else if (ctl.move_wr) begin
      ne_we = 1'b1;
    end else if (ctl.exec) begin
      if (is_app) begin
        ne_we = 1'b1;
        ne_wd = 1'b1;
      end else if (pop_hit && !pop_more) begin
        ne_we = 1'b1;
      end else if (merge_go && !ne_d_rd_r) begin
        ne_we = 1'b1;
        ne_wa = dst_r;
        ne_wd = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r      <= in_cmd;
      q_r        <= qidx(in_queue_id);
      dst_r      <= qidx(in_dest_queue);
      elem_r     <= in_element;
      q_ok_r     <= (32'(in_queue_id) < 32'(NUM_QUEUES));
      dst_ok_r   <= (32'(in_dest_queue) < 32'(NUM_QUEUES));
      elem_ok_r  <= (32'(in_element) < 32'(NUM_ELEMENTS));
      dst_diff_r <= (in_queue_id != in_dest_queue);
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[hd_wa] <= hd_wd;
    end
    if (ctl.accept) begin
      head_rd_r <= head_mem[qidx(in_queue_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (tl_we) begin
      tail_mem[tl_wa] <= tl_wd;
    end
    if (ctl.accept) begin
      tail_q_rd_r <= tail_mem[qidx(in_queue_id)];
      tail_d_rd_r <= tail_mem[qidx(in_dest_queue)];
    end
  end

  always_ff @(posedge clk) begin
    if (ne_we) begin
      ne_mem[ne_wa] <= ne_wd;
    end
    if (ctl.accept) begin
      ne_q_rd_r <= ne_mem[qidx(in_queue_id)];
      ne_d_rd_r <= ne_mem[qidx(in_dest_queue)];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
    if (lk_re) begin
      link_rd_r <= link_mem[eidx(head_rd_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + QW'(1);
    end
  end

  // result register parts the result side from the command side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r <= res_status;
      out_popped_r <= res_popped;
    end
  end

  always_comb begin
    sts.clr_last = (clr_cnt_r == QW'(NUM_QUEUES - 1));
    sts.pop_more = pop_more;
    sts.merge_go = merge_go;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_popped_element = out_popped_r;

endmodule

// ===== design/linked_multi_queue_manager_unit.sv =====
// top level of the linked multi-queue manager
//
//  channel  direction  handshake     word
//  in_ch    input      valid/ready   cmd, queue_id, element, dest_queue
//  out_ch   output     valid/ready   status, popped_element
//
// append, pop of an empty or one-word queue, and merges that change nothing
// finish in ST_EXEC; pop of a longer queue and an effective merge also pass
// through ST_LINK or ST_MOVE, set by the registered link read after the head
// read and the single write port of the non-empty flags. after reset a
// clearing pass runs over all NUM_QUEUES non-empty flags with ready low. the
// result register lets the next word in while a result waits; a command
// finishing against an untaken result holds until out_ch.ready.
module linked_multi_queue_manager_unit import lmq_pkg::*; #(
  parameter int NUM_QUEUES   = 128,
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  lmq_in_if.sink     in_ch,
  lmq_out_if.source  out_ch
);

  lmq_ctl_t ctl;
  lmq_sts_t sts;
  logic     in_ready;

  lmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lmq_dp #(
    .NUM_QUEUES   (NUM_QUEUES),
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_ch.cmd),
    .in_queue_id        (in_ch.queue_id),
    .in_element         (in_ch.element),
    .in_dest_queue      (in_ch.dest_queue),
    .ctl                (ctl),
    .sts                (sts),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_popped_element (out_ch.popped_element)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== design/lmq_chk.sv =====
// port-level checker for the multi-queue manager and its bind
module lmq_chk import lmq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_status,
  input logic [ELEM_W-1:0] out_popped_element
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("command taken while another is in progress");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result with no command outstanding");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_popped_element == '0))
    else $error("empty pop carries an element");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_popped_element)))
    else $error("stalled result word changed");

endmodule

bind linked_multi_queue_manager_unit lmq_chk u_lmq_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_popped_element (out_ch.popped_element)
);
